### hdl/tsaf_pkg.sv
// Shared types, constants and digit helpers for the timestamp text formatter.
`timescale 1ns / 1ps

package tsaf_pkg;

    // Longest character run and the run lengths of each fraction mode.
    localparam int MaxChars   = 24;
    localparam int CountWidth = 5;
    localparam logic [CountWidth-1:0] CharsPlain = 5'd17;
    localparam logic [CountWidth-1:0] CharsMilli = 5'd21;
    localparam logic [CountWidth-1:0] CharsMicro = 5'd24;
    localparam logic [CountWidth-1:0] CharsError = 5'd1;

    // Field limits.
    localparam logic [7:0]  YearLow       = 8'd110;
    localparam logic [7:0]  YearHigh      = 8'd150;
    localparam logic [7:0]  CenturyBase   = 8'd100;
    localparam logic [3:0]  MonthCount    = 4'd12;
    localparam logic [4:0]  HourCount     = 5'd24;
    localparam logic [5:0]  MinuteCount   = 6'd60;
    localparam logic [19:0] FracMilliSpan = 20'd1000;
    localparam logic [19:0] FracMicroMax  = 20'd999999;

    // floor(x / 1000) for any 20-bit x as (x * RecipThousand) >> RecipShift.
    localparam logic [20:0] RecipThousand = 21'd1073742;
    localparam int          RecipShift    = 30;

    // ASCII codes.
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharDash  = 8'h2D;
    localparam logic [7:0] CharColon = 8'h3A;
    localparam logic [7:0] CharDot   = 8'h2E;
    localparam logic [7:0] CharNull  = 8'h00;

    // Configuration register index, taken from paddr[2].
    localparam logic RegFractionMode = 1'b0;

    typedef enum logic [1:0] {
        FRAC_NONE   = 2'd0,
        FRAC_MILLI  = 2'd1,
        FRAC_MICRO  = 2'd2,
        FRAC_UNUSED = 2'd3
    } frac_mode_t;

    typedef struct packed {
        logic [19:0] fraction_value;
        logic [5:0]  second_value;
        logic [5:0]  minute_value;
        logic [4:0]  hour_value;
        logic [4:0]  day_of_month;
        logic [3:0]  month_index;
        logic [7:0]  year_offset;
    } tsaf_time_t;

    typedef struct packed {
        tsaf_time_t  stamp;
        logic        ok;
        logic [9:0]  frac_high;
    } tsaf_split_t;

    typedef struct packed {
        logic [MaxChars-1:0][7:0] chars;
        logic [CountWidth-1:0]    count;
        logic                     error;
    } tsaf_frame_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return CharZero + {4'b0000, d};
    endfunction

    // Two ASCII digits of a value below 100, tens in the upper byte.
    function automatic logic [15:0] two_chars(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] units;
        tens = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (v >= 7'(10 * i)) begin
                tens = 4'(i);
            end
        end
        units = v - ({tens, 3'b000} - {3'b000, tens} - {3'b000, tens});
        units = v - 7'({3'b000, tens} * 7'd10);
        return {digit_char(tens), digit_char(units[3:0])};
    endfunction

    // Three ASCII digits of a value below 1000, hundreds in the upper byte.
    function automatic logic [23:0] three_chars(input logic [9:0] v);
        logic [3:0] hundreds;
        logic [9:0] rest;
        hundreds = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (v >= 10'(100 * i)) begin
                hundreds = 4'(i);
            end
        end
        rest = v - 10'({6'b000000, hundreds} * 10'd100);
        return {digit_char(hundreds), two_chars(rest[6:0])};
    endfunction

endpackage

### hdl/tsaf_check_split.sv
// Validation and millisecond split stage with its pipeline register.
`timescale 1ns / 1ps

module tsaf_check_split
    import tsaf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  frac_mode_t  fraction_mode,
    input  logic        in_valid,
    output logic        in_ready,
    input  tsaf_time_t  in_time,
    output logic        out_valid,
    input  logic        out_ready,
    output tsaf_split_t out_split
);

    logic [39:0] product;
    logic        fields_ok;
    logic        frac_ok;
    tsaf_split_t split_next;
    tsaf_split_t split_reg;
    logic        valid_reg;
    logic        valid_next;

    assign product = 40'(in_time.fraction_value) * 40'(RecipThousand);

    always_comb begin
        fields_ok = (in_time.year_offset > YearLow) && (in_time.year_offset < YearHigh) &&
                    (in_time.month_index < MonthCount) && (in_time.day_of_month != 5'd0) &&
                    (in_time.hour_value < HourCount) &&
                    (in_time.minute_value < MinuteCount) &&
                    (in_time.second_value < MinuteCount);
        unique case (fraction_mode)
            FRAC_MILLI:            frac_ok = in_time.fraction_value < FracMilliSpan;
            FRAC_MICRO:            frac_ok = in_time.fraction_value <= FracMicroMax;
            FRAC_NONE, FRAC_UNUSED: frac_ok = 1'b1;
            default:               frac_ok = 1'b1;
        endcase
        split_next.stamp     = in_time;
        split_next.ok        = fields_ok && frac_ok;
        split_next.frac_high = product[RecipShift +: 10];
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            split_reg <= split_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_split = split_reg;

endmodule

### hdl/tsaf_frame_build.sv
// Turns a checked timestamp into its full character frame.
`timescale 1ns / 1ps

module tsaf_frame_build
    import tsaf_pkg::*;
(
    input  frac_mode_t  fraction_mode,
    input  tsaf_split_t split,
    output tsaf_frame_t frame
);

    logic [19:0] frac_thousands;
    logic [9:0]  frac_low;
    logic [15:0] year_pair;
    logic [15:0] month_pair;
    logic [15:0] day_pair;
    logic [15:0] hour_pair;
    logic [15:0] minute_pair;
    logic [15:0] second_pair;
    logic [23:0] high_triple;
    logic [23:0] low_triple;
    logic [7:0]  century;

    always_comb begin
        frac_thousands = 20'(split.frac_high) * 20'd1000;
        frac_low       = 10'(split.stamp.fraction_value - frac_thousands);
        century        = split.stamp.year_offset - CenturyBase;
        year_pair      = two_chars(century[6:0]);
        month_pair     = two_chars(7'({3'b000, split.stamp.month_index} + 7'd1));
        day_pair       = two_chars({2'b00, split.stamp.day_of_month});
        hour_pair      = two_chars({2'b00, split.stamp.hour_value});
        minute_pair    = two_chars({1'b0, split.stamp.minute_value});
        second_pair    = two_chars({1'b0, split.stamp.second_value});
        high_triple    = three_chars(split.frac_high);
        low_triple     = three_chars(frac_low);

        frame.chars     = '0;
        frame.chars[0]  = digit_char(4'd2);
        frame.chars[1]  = digit_char(4'd0);
        frame.chars[2]  = year_pair[15:8];
        frame.chars[3]  = year_pair[7:0];
        frame.chars[4]  = month_pair[15:8];
        frame.chars[5]  = month_pair[7:0];
        frame.chars[6]  = day_pair[15:8];
        frame.chars[7]  = day_pair[7:0];
        frame.chars[8]  = CharDash;
        frame.chars[9]  = hour_pair[15:8];
        frame.chars[10] = hour_pair[7:0];
        frame.chars[11] = CharColon;
        frame.chars[12] = minute_pair[15:8];
        frame.chars[13] = minute_pair[7:0];
        frame.chars[14] = CharColon;
        frame.chars[15] = second_pair[15:8];
        frame.chars[16] = second_pair[7:0];
        frame.error     = 1'b0;

        unique case (fraction_mode)
            FRAC_MILLI: begin
                frame.chars[17] = CharDot;
                frame.chars[18] = low_triple[23:16];
                frame.chars[19] = low_triple[15:8];
                frame.chars[20] = low_triple[7:0];
                frame.count     = CharsMilli;
            end
            FRAC_MICRO: begin
                frame.chars[17] = CharDot;
                frame.chars[18] = high_triple[23:16];
                frame.chars[19] = high_triple[15:8];
                frame.chars[20] = high_triple[7:0];
                frame.chars[21] = low_triple[23:16];
                frame.chars[22] = low_triple[15:8];
                frame.chars[23] = low_triple[7:0];
                frame.count     = CharsMicro;
            end
            FRAC_NONE, FRAC_UNUSED: begin
                frame.count = CharsPlain;
            end
            default: begin
                frame.count = CharsPlain;
            end
        endcase

        // A failed check replaces the whole run by one null character.
        if (!split.ok) begin
            frame.chars    = '0;
            frame.chars[0] = CharNull;
            frame.count    = CharsError;
            frame.error    = 1'b1;
        end
    end

endmodule

### hdl/tsaf_char_serializer.sv
// Result frame register that shifts out one character per transfer.
`timescale 1ns / 1ps

module tsaf_char_serializer
    import tsaf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  tsaf_frame_t frame,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic [0:0]  m_tuser
);

    logic [MaxChars-1:0][7:0] chars_reg;
    logic [MaxChars-1:0][7:0] chars_next;
    logic [CountWidth-1:0]    count_reg;
    logic [CountWidth-1:0]    count_next;
    logic                     error_reg;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     final_char;
    logic                     load;

    assign final_char = (count_reg == 5'd1);
    assign in_ready   = !valid_reg || (m_tready && final_char);
    assign load       = in_valid && in_ready;

    always_comb begin
        chars_next = chars_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        if (load) begin
            chars_next = frame.chars;
            count_next = frame.count;
            valid_next = 1'b1;
        end else if (valid_reg && m_tready) begin
            for (int i = 0; i < MaxChars - 1; i++) begin
                chars_next[i] = chars_reg[i + 1];
            end
            chars_next[MaxChars-1] = CharNull;
            count_next = count_reg - 5'd1;
            valid_next = !final_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        chars_reg <= chars_next;
        if (load) begin
            error_reg <= frame.error;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = chars_reg[0];
    assign m_tlast  = final_char;
    assign m_tuser  = error_reg;

endmodule

### hdl/timestamp_to_ascii_formatter_unit.sv
// Top level of the timestamp text formatter: ports, input register and settings.
`timescale 1ns / 1ps
// The first character of a timestamp is offered on m_tvalid once it has passed the input
// register, then the check/split register, then the frame register.
// One character leaves per cycle while m_tready is high, and a timestamp is a run of 17,
// 21 or 24 characters by fraction mode, or one character for an error result; the output
// port sets the pace at which timestamps leave.
// Reset (aresetn, synchronous, active low) empties every stage and sets fraction_mode to 0.

module timestamp_to_ascii_formatter_unit
    import tsaf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] year_offset, [11:8] month_index, [16:12] day_of_month, [21:17] hour_value,
    // [27:22] minute_value, [33:28] second_value, [53:34] fraction_value, [55:54] zero
    input  logic [55:0] s_tdata,

    // Character stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] text_char
    output logic        m_tlast,   // last_char
    output logic [0:0]  m_tuser,   // [0] status_code

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The single register sits at byte address 0; paddr[2] selects the register index.
    frac_mode_t  fraction_mode_reg;
    logic        cfg_write;

    // Input register: holds one timestamp until the check stage takes it.
    tsaf_time_t  in_time_reg;
    logic        in_valid_reg;
    logic        in_valid_next;

    logic        check_ready;
    logic        split_valid;
    tsaf_split_t split;
    logic        frame_ready;
    tsaf_frame_t frame;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegFractionMode);
    assign prdata    = (paddr[2] == RegFractionMode) ? {30'd0, fraction_mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fraction_mode_reg <= FRAC_NONE;
        end else if (cfg_write) begin
            fraction_mode_reg <= frac_mode_t'(pwdata[1:0]);
        end
    end

    // The input register accepts a new transfer whenever it is empty or being drained, so a
    // timestamp can enter while the output is busy with another, until it is full and cannot drain.
    assign s_tready      = !in_valid_reg || check_ready;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !check_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_time_reg.year_offset    <= s_tdata[7:0];
            in_time_reg.month_index    <= s_tdata[11:8];
            in_time_reg.day_of_month   <= s_tdata[16:12];
            in_time_reg.hour_value     <= s_tdata[21:17];
            in_time_reg.minute_value   <= s_tdata[27:22];
            in_time_reg.second_value   <= s_tdata[33:28];
            in_time_reg.fraction_value <= s_tdata[53:34];
        end
    end

    // Range checks and the thousands part of the fraction; the remainder follows in the frame build.
    tsaf_check_split u_check_split (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fraction_mode (fraction_mode_reg),
        .in_valid      (in_valid_reg),
        .in_ready      (check_ready),
        .in_time       (in_time_reg),
        .out_valid     (split_valid),
        .out_ready     (frame_ready),
        .out_split     (split)
    );

    // Digit conversion and layout of the whole text run.
    tsaf_frame_build u_frame_build (
        .fraction_mode (fraction_mode_reg),
        .split         (split),
        .frame         (frame)
    );

    // Frame register that also drives the character stream; it reloads on the cycle the
    // final character transfers, so runs follow one another without a gap.
    tsaf_char_serializer u_char_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (split_valid),
        .in_ready (frame_ready),
        .frame    (frame),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // An error result is a lone null character that closes its run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == CharNull))
        else $error("error result is not a single null character");

    // Inside a run the characters come back to back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("character run broken before its last character");

    // A timestamp character is never the null code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata != CharNull))
        else $error("null character inside a timestamp run");

endmodule

### bench/testbench.sv
// Self-checking testbench of the timestamp text formatter, with its character scoreboard.
`timescale 1ns / 1ps

module testbench;
    import tsaf_pkg::*;

    // The watchdog limit is far above the longest quiet stretch of a correct run.
    // That stretch is the settle pause before a register write, or a stall on either side.
    localparam int WatchdogLimit = 2000;
    localparam int SettleCycles  = 12;
    localparam int IdlePercent   = 13;
    localparam int ShowLimit     = 10;
    localparam int PhaseItems    = 56;
    localparam int SteadyPhase   = 3;

    typedef struct {
        logic [7:0] text_char;
        logic       last_char;
        logic       status_code;
    } char_result_t;

    // Predicts the character runs of accepted timestamps and checks them in order.
    class char_scoreboard;
        char_result_t pending[$];
        int           errors;

        function void report(string msg);
            errors++;
            if (errors <= ShowLimit) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        function void push_char(logic [7:0] c);
            char_result_t r;
            r.text_char   = c;
            r.last_char   = 1'b0;
            r.status_code = 1'b0;
            pending.push_back(r);
        endfunction

        function void push_pair(int v);
            push_char(CharZero + 8'((v / 10) % 10));
            push_char(CharZero + 8'(v % 10));
        endfunction

        // Works out the run that one accepted timestamp causes under the given mode.
        function void note_stamp(tsaf_time_t t, frac_mode_t mode);
            bit           ok;
            int           year;
            int           frac;
            int           div;
            char_result_t err;
            ok = t.year_offset > 8'd110 && t.year_offset < 8'd150 &&
                 t.month_index < 4'd12 && t.day_of_month != 5'd0 &&
                 t.hour_value < 5'd24 && t.minute_value < 6'd60 && t.second_value < 6'd60;
            frac = int'(t.fraction_value);
            if (mode == FRAC_MILLI && frac >= 1000) begin
                ok = 1'b0;
            end
            if (mode == FRAC_MICRO && frac > 999999) begin
                ok = 1'b0;
            end
            if (!ok) begin
                err.text_char   = CharNull;
                err.last_char   = 1'b1;
                err.status_code = 1'b1;
                pending.push_back(err);
                return;
            end
            year = 1900 + int'(t.year_offset);
            push_pair(year / 100);
            push_pair(year % 100);
            push_pair(int'(t.month_index) + 1);
            push_pair(int'(t.day_of_month));
            push_char(CharDash);
            push_pair(int'(t.hour_value));
            push_char(CharColon);
            push_pair(int'(t.minute_value));
            push_char(CharColon);
            push_pair(int'(t.second_value));
            if (mode == FRAC_MILLI || mode == FRAC_MICRO) begin
                push_char(CharDot);
                div = (mode == FRAC_MILLI) ? 100 : 100000;
                for (int d = div; d > 0; d /= 10) begin
                    push_char(CharZero + 8'((frac / d) % 10));
                end
            end
            pending[pending.size() - 1].last_char = 1'b1;
        endfunction

        function void check_char(logic [7:0] text_char, logic last_char, logic status_code);
            char_result_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected char %h last %b status %b",
                                 text_char, last_char, status_code));
                return;
            end
            want = pending.pop_front();
            if (text_char !== want.text_char || last_char !== want.last_char ||
                status_code !== want.status_code) begin
                report($sformatf("char exp %h/%b/%b got %h/%b/%b",
                                 want.text_char, want.last_char, want.status_code,
                                 text_char, last_char, status_code));
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    char_scoreboard sb;
    frac_mode_t     cur_mode;
    bit             steady;
    int             quiet_cycles;

    timestamp_to_ascii_formatter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The receiver stalls at random, except during the steady phase.
    always @(negedge aclk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= IdlePercent);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_char(m_tdata, m_tlast, m_tuser[0]);
        end
    end

    // Any transfer or register access restarts the count of quiet cycles.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic tsaf_time_t make_stamp(int yr, int mo, int dy, int hr, int mi, int se,
                                              int fr);
        tsaf_time_t t;
        t.year_offset    = 8'(yr);
        t.month_index    = 4'(mo);
        t.day_of_month   = 5'(dy);
        t.hour_value     = 5'(hr);
        t.minute_value   = 6'(mi);
        t.second_value   = 6'(se);
        t.fraction_value = 20'(fr);
        return t;
    endfunction

    // Mostly well-formed timestamps with random content; the rest is raw noise.
    function automatic tsaf_time_t random_stamp(frac_mode_t mode);
        tsaf_time_t t;
        int         fr;
        if ($urandom_range(99) < 25) begin
            t = tsaf_time_t'(54'({$urandom, $urandom}));
            return t;
        end
        fr = $urandom_range(20'hFFFFF);
        if ($urandom_range(99) >= 10) begin
            if (mode == FRAC_MILLI) begin
                fr = $urandom_range(999);
            end else if (mode == FRAC_MICRO) begin
                fr = $urandom_range(999999);
            end
        end
        t = make_stamp($urandom_range(149, 111), $urandom_range(11), $urandom_range(31, 1),
                       $urandom_range(23), $urandom_range(59), $urandom_range(59), fr);
        return t;
    endfunction

    task automatic send_stamp(input tsaf_time_t stamp);
        while (!steady && $urandom_range(99) < IdlePercent) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, stamp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_stamp(stamp, cur_mode);
        @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr[2] == RegFractionMode) begin
            cur_mode = frac_mode_t'(value[1:0]);
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want) begin
            sb.report($sformatf("register read exp %h got %h", want, prdata));
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Waits for every expected character, lets the pipeline settle, then sets the mode.
    // A write to the unlisted index, which must change nothing, goes with it at random.
    task automatic set_mode(input frac_mode_t mode);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
        @(negedge aclk);
        apb_write({RegFractionMode, 2'b00}, {30'($urandom_range(32'h3FFFFFFF)), mode});
        if ($urandom_range(1) == 1) begin
            apb_write({~RegFractionMode, 2'b00}, $urandom);
        end
        apb_read_check({RegFractionMode, 2'b00}, {30'd0, mode});
    endtask

    frac_mode_t phase_modes[8] = '{FRAC_MILLI, FRAC_MICRO, FRAC_NONE, FRAC_UNUSED,
                                   FRAC_MICRO, FRAC_MILLI, FRAC_NONE, FRAC_MICRO};

    initial begin
        sb       = new();
        cur_mode = FRAC_NONE;
        steady   = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Field extremes after reset, with no fraction; a huge fraction is ignored here.
        send_stamp(make_stamp(111, 0, 1, 0, 0, 0, 0));
        send_stamp(make_stamp(149, 11, 31, 23, 59, 59, 20'hFFFFF));
        send_stamp(make_stamp(124, 1, 31, 12, 30, 45, 0));
        send_stamp(make_stamp(110, 5, 10, 10, 10, 10, 0));
        send_stamp(make_stamp(150, 5, 10, 10, 10, 10, 0));
        send_stamp(make_stamp(0, 0, 0, 0, 0, 0, 0));
        send_stamp(make_stamp(255, 15, 31, 31, 63, 63, 20'hFFFFF));
        send_stamp(make_stamp(120, 12, 10, 10, 10, 10, 0));
        send_stamp(make_stamp(120, 15, 10, 10, 10, 10, 0));
        send_stamp(make_stamp(120, 3, 0, 10, 10, 10, 0));
        send_stamp(make_stamp(120, 3, 10, 24, 10, 10, 0));
        send_stamp(make_stamp(120, 3, 10, 31, 10, 10, 0));
        send_stamp(make_stamp(120, 3, 10, 10, 60, 10, 0));
        send_stamp(make_stamp(120, 3, 10, 10, 63, 10, 0));
        send_stamp(make_stamp(120, 3, 10, 10, 10, 60, 0));
        send_stamp(make_stamp(120, 3, 10, 10, 10, 63, 0));

        // Fraction bounds in the millisecond and microsecond modes.
        set_mode(FRAC_MILLI);
        send_stamp(make_stamp(123, 5, 15, 8, 7, 6, 999));
        send_stamp(make_stamp(123, 5, 15, 8, 7, 6, 1000));
        send_stamp(make_stamp(123, 5, 15, 8, 7, 6, 7));
        set_mode(FRAC_MICRO);
        send_stamp(make_stamp(130, 9, 9, 9, 9, 9, 999999));
        send_stamp(make_stamp(130, 9, 9, 9, 9, 9, 1000000));
        send_stamp(make_stamp(130, 9, 9, 9, 9, 9, 20'hFFFFF));
        send_stamp(make_stamp(130, 9, 9, 9, 9, 9, 5));

        // The unused mode prints no fraction and never checks it.
        set_mode(FRAC_UNUSED);
        send_stamp(make_stamp(140, 6, 20, 18, 45, 30, 20'hFFFFF));

        for (int p = 0; p < 8; p++) begin
            set_mode(phase_modes[p]);
            steady = (p == SteadyPhase);
            for (int i = 0; i < PhaseItems; i++) begin
                send_stamp(random_stamp(cur_mode));
            end
            steady = 1'b0;
        end
        s_tvalid = 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
